/* hw/rtl/clarke_park_frame_transform_assert.svh */
// Assertion macros shared by the frame transform RTL.
`ifndef CLARKE_PARK_FRAME_TRANSFORM_ASSERT_SVH
`define CLARKE_PARK_FRAME_TRANSFORM_ASSERT_SVH

// Checked property, switched off while reset is held
`define CPFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also covers the reset cycles
`define CPFT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/cpft_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants, sine table and arithmetic helpers for the frame transform.
package cpft_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int ANGLE_W    = 16;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_IDX_W = $clog2(SINE_DEPTH);
  localparam int ROM_W      = 15;
  localparam int ROM_BITS   = (SINE_DEPTH + 1) * ROM_W;

  // Internal arithmetic widths: 18-bit multiplier operands, 36-bit products and sums
  localparam int MUL_W  = 18;
  localparam int WIDE_W = 36;
  localparam int Q_FRAC = 15;

  // Stream packing
  localparam int IN_DATA_W  = ((3 * SAMPLE_W + ANGLE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((5 * SAMPLE_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MUL_W-1:0]    mop_t;
  typedef logic signed [WIDE_W-1:0]   wide_t;

  typedef enum logic {
    REQ_FWD = 1'b0,
    REQ_INV = 1'b1
  } req_t;

  // Q1.15 coefficients
  localparam mop_t Q_ONE_THIRD  = MUL_W'(10923);
  localparam mop_t Q_INV_SQRT3  = MUL_W'(18919);
  localparam mop_t Q_SQRT3_HALF = MUL_W'(28378);
  localparam mop_t Q_HALF       = MUL_W'(16384);

  localparam wide_t ROUND_BIAS = wide_t'(longint'(1) << (Q_FRAC - 1));
  localparam wide_t SMAX_W     = wide_t'((longint'(1) << (SAMPLE_W - 1)) - 1);
  localparam wide_t SMIN_W     = wide_t'(-(longint'(1) << (SAMPLE_W - 1)));

  // Sine table generation (Q30 Taylor series to x^15)
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint TAYLOR_DEN [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                        64'sd110, 64'sd156, 64'sd210};

  typedef struct packed {
    req_t                 req;
    sample_t              a;
    sample_t              b;
    sample_t              c;
    logic [ANGLE_W-1:0]   angle;
  } in_item_t;

  // After the sine lookup and Clarke pre-sums
  typedef struct packed {
    req_t    req;
    sample_t a;
    sample_t b;
    sample_t c;
    sample_t s;
    sample_t co;
    mop_t    sa;
    mop_t    sb;
    mop_t    sz;
  } s1_t;

  // After the first multiplier rank
  typedef struct packed {
    req_t    req;
    sample_t c;
    sample_t s;
    sample_t co;
    wide_t   p0;
    wide_t   p1;
    wide_t   p2;
    wide_t   p3;
  } s2_t;

  // Stationary frame values, handed from front to back half
  typedef struct packed {
    req_t    req;
    sample_t s;
    sample_t co;
    sample_t al;
    sample_t be;
    sample_t z;
    logic    clip;
  } mid_t;

  // After the second multiplier rank
  typedef struct packed {
    req_t    req;
    sample_t al;
    sample_t be;
    sample_t z;
    logic    clip;
    wide_t   q0;
    wide_t   q1;
    wide_t   q2;
    wide_t   q3;
  } s4_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    sample_t alpha;
    sample_t beta;
    logic    clip;
  } out_item_t;

  typedef struct packed {
    sample_t val;
    logic    clip;
  } sat_t;

  function automatic logic [ROM_BITS-1:0] build_sine_rom();
    logic [ROM_BITS-1:0] rom;
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    rom = '0;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
      x2   = (x * x) / ONE_Q30;
      term = x;
      sum  = x;
      for (int n = 0; n < 7; n++) begin
        term = (term * x2) / ONE_Q30;
        term = -(term / TAYLOR_DEN[n]);
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum * 32767 + (ONE_Q30 / 2)) / ONE_Q30;
      if (v > 32767) begin
        v = 32767;
      end
      rom[k*ROM_W +: ROM_W] = ROM_W'(v);
    end
    return rom;
  endfunction

  localparam logic [ROM_BITS-1:0] SINE_ROM = build_sine_rom();

  // Round half up from Q30 back to Q15
  function automatic wide_t round_q15(input wide_t v);
    return (v + ROUND_BIAS) >>> Q_FRAC;
  endfunction

  // Clamp to the sample range and report clipping
  function automatic sat_t saturate(input wide_t v);
    sat_t r;
    if (v > SMAX_W) begin
      r.val  = sample_t'(SMAX_W);
      r.clip = 1'b1;
    end else if (v < SMIN_W) begin
      r.val  = sample_t'(SMIN_W);
      r.clip = 1'b1;
    end else begin
      r.val  = sample_t'(v);
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic wide_t mul(input mop_t x, input mop_t y);
    return x * y;
  endfunction

endpackage

/* hw/rtl/clarke_park_frame_transform.sv */
`timescale 1ns / 1ps
// Top level of the Clarke/Park frame transform with stream ports.
`include "clarke_park_frame_transform_assert.svh"

// Amplitude-invariant abc <-> dq0 transform on Q1.15 samples. in_tuser selects
// the direction (0: abc to dq0, 1: dq0 to abc); sine and cosine come from a
// quarter-wave table indexed by the upper angle bits. The block takes one
// transaction per clock. There are five register stages: table lookup, first
// multiplier rank, first round-and-clamp, second multiplier rank, and the final
// round-and-clamp into the output register. The first stage loads on the edge
// that takes the input; out_tvalid rises when the item reaches the output
// register. The whole pipeline stalls while a result waits on out_tready.
// out_tuser reports clipping anywhere in the item.
module clarke_park_frame_transform (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cpft_pkg::IN_DATA_W-1:0]     in_tdata,   // in_a, in_b, in_c, angle
  input  logic                               in_tuser,   // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cpft_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_a, out_b, out_c, out_alpha, out_beta
  output logic                               out_tuser   // clipped
);

  cpft_pkg::in_item_t  in_item;
  cpft_pkg::mid_t      mid;
  cpft_pkg::out_item_t out_item;
  logic [2:0]          front_valid;
  logic [1:0]          back_valid;
  logic [4:0]          pipe_valid;
  logic                pipe_en;

  // Pipeline moves whenever the output register is empty or being taken
  assign pipe_en   = !out_tvalid || out_tready;
  assign in_tready = pipe_en;

  // Unpack the input transaction
  assign in_item.req   = cpft_pkg::req_t'(in_tuser);
  assign in_item.a     = in_tdata[0 +: cpft_pkg::SAMPLE_W];
  assign in_item.b     = in_tdata[cpft_pkg::SAMPLE_W +: cpft_pkg::SAMPLE_W];
  assign in_item.c     = in_tdata[2*cpft_pkg::SAMPLE_W +: cpft_pkg::SAMPLE_W];
  assign in_item.angle = in_tdata[3*cpft_pkg::SAMPLE_W +: cpft_pkg::ANGLE_W];

  cpft_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (in_tvalid),
    .in_item  (in_item),
    .mid      (mid),
    .valid    (front_valid)
  );

  cpft_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .mid_valid (front_valid[2]),
    .mid       (mid),
    .out_item  (out_item),
    .valid     (back_valid)
  );

  // Pack the result transaction
  assign pipe_valid = {back_valid, front_valid};
  assign out_tvalid = back_valid[1];
  assign out_tdata  = cpft_pkg::OUT_DATA_W'({out_item.beta, out_item.alpha, out_item.c,
                                             out_item.b, out_item.a});
  assign out_tuser  = out_item.clip;

  // Pipeline checks
  `CPFT_ASSERT_RST(a_reset_empties, !rst_n |=> $countones(pipe_valid) == 0, "pipeline not empty after reset")
  `CPFT_ASSERT(a_stall_blocks_input, out_tvalid && !out_tready |-> !in_tready, "input taken during stall")
  `CPFT_ASSERT(a_entry_valid, in_tready |=> pipe_valid[0] == $past(in_tvalid), "entry valid lost")
  `CPFT_ASSERT(a_valid_shift, in_tready |=> pipe_valid[4:1] == $past(pipe_valid[3:0]), "valid bits did not advance")
  `CPFT_ASSERT(a_stall_holds, !in_tready |=> $stable(pipe_valid), "valid bits moved during stall")

endmodule

/* hw/rtl/cpft_sincos.sv */
`timescale 1ns / 1ps
// Quarter-wave table lookup giving sine and cosine of the electrical angle.
module cpft_sincos (
  input  logic [cpft_pkg::ANGLE_W-1:0] angle,
  output cpft_pkg::sample_t            sin_val,
  output cpft_pkg::sample_t            cos_val
);

  logic [1:0]                      quad;
  logic [1:0]                      quad_cos;
  logic [cpft_pkg::SINE_IDX_W-1:0] idx;

  // Mirror the index in odd quadrants, negate in the lower half turn
  function automatic cpft_pkg::sample_t quarter_lookup(
    input logic [1:0] q,
    input logic [cpft_pkg::SINE_IDX_W-1:0] i
  );
    logic [cpft_pkg::SINE_IDX_W:0] addr;
    logic [cpft_pkg::ROM_W-1:0]    mag;
    cpft_pkg::sample_t             v;
    addr = q[0] ? ((cpft_pkg::SINE_IDX_W + 1)'(cpft_pkg::SINE_DEPTH) - {1'b0, i})
                : {1'b0, i};
    mag  = cpft_pkg::SINE_ROM[addr*cpft_pkg::ROM_W +: cpft_pkg::ROM_W];
    v    = cpft_pkg::sample_t'(mag);
    return q[1] ? -v : v;
  endfunction

  assign quad     = angle[cpft_pkg::ANGLE_W-1 -: 2];
  assign quad_cos = quad + 2'd1;
  assign idx      = angle[cpft_pkg::ANGLE_W-3 -: cpft_pkg::SINE_IDX_W];

  assign sin_val = quarter_lookup(quad, idx);
  assign cos_val = quarter_lookup(quad_cos, idx);

endmodule

/* hw/rtl/cpft_front.sv */
`timescale 1ns / 1ps
// Front half: angle lookup, Clarke or inverse Park products, first rounding.
module cpft_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  cpft_pkg::in_item_t   in_item,
  output cpft_pkg::mid_t       mid,
  output logic [2:0]           valid
);

  cpft_pkg::s1_t  s1_nxt, s1_r;
  cpft_pkg::s2_t  s2_nxt, s2_r;
  cpft_pkg::mid_t s3_nxt, s3_r;
  logic [2:0]     valid_r;

  cpft_pkg::sample_t sin_w;
  cpft_pkg::sample_t cos_w;

  cpft_sincos u_sincos (
    .angle   (in_item.angle),
    .sin_val (sin_w),
    .cos_val (cos_w)
  );

  // Stage 1: table values and Clarke pre-sums
  always_comb begin
    cpft_pkg::mop_t ea, eb, ec;
    ea        = cpft_pkg::mop_t'(in_item.a);
    eb        = cpft_pkg::mop_t'(in_item.b);
    ec        = cpft_pkg::mop_t'(in_item.c);
    s1_nxt.req = in_item.req;
    s1_nxt.a   = in_item.a;
    s1_nxt.b   = in_item.b;
    s1_nxt.c   = in_item.c;
    s1_nxt.s   = sin_w;
    s1_nxt.co  = cos_w;
    s1_nxt.sa  = (ea <<< 1) - eb - ec;
    s1_nxt.sb  = eb - ec;
    s1_nxt.sz  = ea + eb + ec;
  end

  // Stage 2: four shared multipliers; the first three take operands chosen by direction
  always_comb begin
    logic fwd;
    cpft_pkg::mop_t x0, y0, x1, y1, x2, y2, x3, y3;
    fwd = (s1_r.req == cpft_pkg::REQ_FWD);
    x0  = fwd ? s1_r.sa : cpft_pkg::mop_t'(s1_r.co);
    y0  = fwd ? cpft_pkg::Q_ONE_THIRD : cpft_pkg::mop_t'(s1_r.a);
    x1  = fwd ? s1_r.sb : cpft_pkg::mop_t'(s1_r.s);
    y1  = fwd ? cpft_pkg::Q_INV_SQRT3 : cpft_pkg::mop_t'(s1_r.b);
    x2  = fwd ? s1_r.sz : cpft_pkg::mop_t'(s1_r.s);
    y2  = fwd ? cpft_pkg::Q_ONE_THIRD : cpft_pkg::mop_t'(s1_r.a);
    x3  = cpft_pkg::mop_t'(s1_r.co);
    y3  = cpft_pkg::mop_t'(s1_r.b);
    s2_nxt.req = s1_r.req;
    s2_nxt.c   = s1_r.c;
    s2_nxt.s   = s1_r.s;
    s2_nxt.co  = s1_r.co;
    s2_nxt.p0  = cpft_pkg::mul(x0, y0);
    s2_nxt.p1  = cpft_pkg::mul(x1, y1);
    s2_nxt.p2  = cpft_pkg::mul(x2, y2);
    s2_nxt.p3  = cpft_pkg::mul(x3, y3);
  end

  // Stage 3: round and clamp alpha, beta and, in the forward direction, the zero sequence
  always_comb begin
    cpft_pkg::sat_t al, be, zs;
    if (s2_r.req == cpft_pkg::REQ_FWD) begin
      al = cpft_pkg::saturate(cpft_pkg::round_q15(s2_r.p0));
      be = cpft_pkg::saturate(cpft_pkg::round_q15(s2_r.p1));
      zs = cpft_pkg::saturate(cpft_pkg::round_q15(s2_r.p2));
    end else begin
      al = cpft_pkg::saturate(cpft_pkg::round_q15(s2_r.p0 - s2_r.p1));
      be = cpft_pkg::saturate(cpft_pkg::round_q15(s2_r.p2 + s2_r.p3));
      zs.val  = s2_r.c;
      zs.clip = 1'b0;
    end
    s3_nxt.req  = s2_r.req;
    s3_nxt.s    = s2_r.s;
    s3_nxt.co   = s2_r.co;
    s3_nxt.al   = al.val;
    s3_nxt.be   = be.val;
    s3_nxt.z    = zs.val;
    s3_nxt.clip = al.clip | be.clip | zs.clip;
  end

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign mid   = s3_r;
  assign valid = valid_r;

endmodule

/* hw/rtl/cpft_back.sv */
`timescale 1ns / 1ps
// Back half: Park or inverse Clarke products, final rounding and output register.
module cpft_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 mid_valid,
  input  cpft_pkg::mid_t       mid,
  output cpft_pkg::out_item_t  out_item,
  output logic [1:0]           valid
);

  cpft_pkg::s4_t       s4_nxt, s4_r;
  cpft_pkg::out_item_t out_nxt, out_r;
  logic [1:0]          valid_r;

  // Stage 4: rotation products, or the inverse Clarke halves
  always_comb begin
    logic fwd;
    cpft_pkg::mop_t x0, y0, x1, y1;
    fwd = (mid.req == cpft_pkg::REQ_FWD);
    x0  = cpft_pkg::mop_t'(fwd ? mid.co : mid.al);
    y0  = fwd ? cpft_pkg::mop_t'(mid.al) : cpft_pkg::Q_HALF;
    x1  = cpft_pkg::mop_t'(fwd ? mid.s : mid.be);
    y1  = fwd ? cpft_pkg::mop_t'(mid.be) : cpft_pkg::Q_SQRT3_HALF;
    s4_nxt.req  = mid.req;
    s4_nxt.al   = mid.al;
    s4_nxt.be   = mid.be;
    s4_nxt.z    = mid.z;
    s4_nxt.clip = mid.clip;
    s4_nxt.q0   = cpft_pkg::mul(x0, y0);
    s4_nxt.q1   = cpft_pkg::mul(x1, y1);
    s4_nxt.q2   = cpft_pkg::mul(cpft_pkg::mop_t'(mid.co), cpft_pkg::mop_t'(mid.be));
    s4_nxt.q3   = cpft_pkg::mul(cpft_pkg::mop_t'(mid.s), cpft_pkg::mop_t'(mid.al));
  end

  // Stage 5: sum, round and clamp the outputs; in the forward direction the zero sequence passes through
  always_comb begin
    cpft_pkg::sat_t r0, r1, r2;
    cpft_pkg::wide_t zw;
    zw = cpft_pkg::wide_t'(s4_r.z);
    if (s4_r.req == cpft_pkg::REQ_FWD) begin
      r0 = cpft_pkg::saturate(cpft_pkg::round_q15(s4_r.q0 + s4_r.q1));
      r1 = cpft_pkg::saturate(cpft_pkg::round_q15(s4_r.q2 - s4_r.q3));
      r2.val  = s4_r.z;
      r2.clip = 1'b0;
    end else begin
      r0 = cpft_pkg::saturate(cpft_pkg::wide_t'(s4_r.al) + zw);
      r1 = cpft_pkg::saturate(cpft_pkg::round_q15(s4_r.q1 - s4_r.q0) + zw);
      r2 = cpft_pkg::saturate(cpft_pkg::round_q15(-s4_r.q0 - s4_r.q1) + zw);
    end
    out_nxt.a     = r0.val;
    out_nxt.b     = r1.val;
    out_nxt.c     = r2.val;
    out_nxt.alpha = s4_r.al;
    out_nxt.beta  = s4_r.be;
    out_nxt.clip  = s4_r.clip | r0.clip | r1.clip | r2.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[0], mid_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r  <= s4_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;
  assign valid    = valid_r;

endmodule

/* tb/clarke_park_frame_transform_test.sv */
`timescale 1ns / 1ps
// Self-checking stream test of the Clarke/Park frame transform with a bit-exact predictor.
module clarke_park_frame_transform_test;
  import cpft_pkg::*;

  // Holds the transform predictor and the queue of outputs still awaited
  class transform_checker;
    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint THIRD_Q15   = 10923;
    localparam longint RSQRT3_Q15  = 18919;
    localparam longint SQ3HALF_Q15 = 28378;
    localparam longint HALF_Q15    = 16384;
    localparam int     TABLE_LEN   = 256;

    longint      sine_q15[0:TABLE_LEN];
    out_item_t   awaited_outputs[$];
    int          errors;
    bit          clip_seen;

    // Quarter-wave table: Q30 Taylor series to x^15, scaled to Q15
    function new();
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint v;
      errors = 0;
      for (int k = 0; k <= TABLE_LEN; k++) begin
        x    = (HALF_PI_Q30 * longint'(k)) / TABLE_LEN;
        x2   = (x * x) / ONE_Q30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 7; n++) begin
          term = (term * x2) / ONE_Q30;
          term = -(term / longint'((2 * n) * (2 * n + 1)));
          sum  = sum + term;
        end
        if (sum < 0) sum = 0;
        v = (sum * 32767 + (ONE_Q30 / 2)) / ONE_Q30;
        if (v > 32767) v = 32767;
        sine_q15[k] = v;
      end
    endfunction

    function longint table_sine(logic [ANGLE_W-1:0] ang);
      logic [7:0] idx;
      longint     v;
      idx = ang[13:6];
      if (ang[14]) v = sine_q15[TABLE_LEN - idx];
      else v = sine_q15[idx];
      return ang[15] ? -v : v;
    endfunction

    // Round half up from Q30 to Q15
    function longint round_q15(longint v);
      return (v + 64'sd16384) >>> 15;
    endfunction

    function longint clamp(longint v);
      if (v > 32767) begin
        clip_seen = 1'b1;
        return 32767;
      end
      if (v < -32768) begin
        clip_seen = 1'b1;
        return -32768;
      end
      return v;
    endfunction

    function out_item_t predict_transform(req_t req, sample_t a, sample_t b, sample_t c,
                                          logic [ANGLE_W-1:0] ang);
      out_item_t r;
      longint    xa;
      longint    xb;
      longint    xc;
      longint    s;
      longint    co;
      longint    al;
      longint    be;
      longint    r0;
      longint    r1;
      longint    r2;
      xa = a;
      xb = b;
      xc = c;
      clip_seen = 1'b0;
      s  = table_sine(ang);
      co = table_sine(ang + 16'h4000);
      if (req == REQ_FWD) begin
        // Clarke then Park
        al = clamp(round_q15((2 * xa - xb - xc) * THIRD_Q15));
        be = clamp(round_q15((xb - xc) * RSQRT3_Q15));
        r2 = clamp(round_q15((xa + xb + xc) * THIRD_Q15));
        r0 = clamp(round_q15(co * al + s * be));
        r1 = clamp(round_q15(co * be - s * al));
      end else begin
        // Inverse Park then inverse Clarke
        al = clamp(round_q15(co * xa - s * xb));
        be = clamp(round_q15(s * xa + co * xb));
        r0 = clamp(al + xc);
        r1 = clamp(round_q15(-al * HALF_Q15 + be * SQ3HALF_Q15) + xc);
        r2 = clamp(round_q15(-al * HALF_Q15 - be * SQ3HALF_Q15) + xc);
      end
      r.a     = sample_t'(r0);
      r.b     = sample_t'(r1);
      r.c     = sample_t'(r2);
      r.alpha = sample_t'(al);
      r.beta  = sample_t'(be);
      r.clip  = clip_seen;
      return r;
    endfunction

    function void record_vector(req_t req, sample_t a, sample_t b, sample_t c,
                                logic [ANGLE_W-1:0] ang);
      awaited_outputs.push_back(predict_transform(req, a, b, c, ang));
    endfunction

    function void compare_field(string label, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_output(logic [OUT_DATA_W-1:0] data, logic flag);
      out_item_t want;
      if (awaited_outputs.size() == 0) begin
        $display("%0t: unexpected output transaction, expected none actual %h/%b",
                 $time, data, flag);
        errors++;
        return;
      end
      want = awaited_outputs.pop_front();
      compare_field("out_a", want.a, sample_t'(data[15:0]));
      compare_field("out_b", want.b, sample_t'(data[31:16]));
      compare_field("out_c", want.c, sample_t'(data[47:32]));
      compare_field("out_alpha", want.alpha, sample_t'(data[63:48]));
      compare_field("out_beta", want.beta, sample_t'(data[79:64]));
      compare_field("clipped", want.clip, flag);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;   // in_a, in_b, in_c, angle
  logic                    in_tuser;   // req_type
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;  // out_a, out_b, out_c, out_alpha, out_beta
  logic                    out_tuser;  // clipped

  transform_checker sb;
  bit               tx_gaps;
  bit               rx_stalls;

  clarke_park_frame_transform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Mostly short idle stretches, now and then a long one
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return sample_t'($urandom);
    if (r < 8) return sample_t'($urandom_range(0, 16383) - 8192);
    if (r == 8) begin
      if ($urandom_range(0, 1)) return sample_t'(32767 - $urandom_range(0, 15));
      return sample_t'(-32768 + $urandom_range(0, 15));
    end
    return sample_t'($urandom_range(0, 7) - 4);
  endfunction

  function automatic logic [ANGLE_W-1:0] rand_angle();
    logic [1:0] quad;
    quad = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0: return {quad, 14'($urandom_range(0, 127))};
      1: return {quad, 14'(16383 - $urandom_range(0, 127))};
      default: return 16'($urandom);
    endcase
  endfunction

  // One transaction on the input channel, then an optional idle gap
  task automatic send_vector(input req_t req, input sample_t a, input sample_t b,
                             input sample_t c, input logic [ANGLE_W-1:0] ang);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {ang, c, b, a};
    do @(posedge clk); while (!in_tready);
    sb.record_vector(req, a, b, c, ang);
    if (tx_gaps && $urandom_range(0, 1)) begin
      gap = gap_length();
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random();
    send_vector(req_t'($urandom_range(0, 1)), rand_sample(), rand_sample(), rand_sample(),
                rand_angle());
  endtask

  // Hold off the sender until every awaited output has been seen
  task automatic drain_outputs();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.awaited_outputs.size() != 0) @(posedge clk);
  endtask

  // Output side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_stalls && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
    end
  end

  // Score every output transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tuser);
  end

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, both directions, quadrant edges, intermediate and output clipping
    send_vector(REQ_FWD, 0, 0, 0, 16'h0000);
    send_vector(REQ_FWD, 32767, -32768, -32768, 16'h0000);
    send_vector(REQ_FWD, -32768, 32767, 32767, 16'h4000);
    send_vector(REQ_FWD, 32767, 32767, 32767, 16'h8000);
    send_vector(REQ_FWD, -32768, -32768, -32768, 16'hC000);
    send_vector(REQ_FWD, 0, 32767, -32768, 16'h2000);
    send_vector(REQ_FWD, 16384, -8192, -8192, 16'hFFFF);
    send_vector(REQ_FWD, 10000, -5000, -5000, 16'h3FFF);
    send_vector(REQ_FWD, 10000, -5000, -5000, 16'h0040);
    send_vector(REQ_FWD, 12000, 3000, -15000, 16'h003F);
    send_vector(REQ_FWD, 1, -1, 0, 16'h7FFF);
    send_vector(REQ_INV, 0, 0, 0, 16'h0000);
    send_vector(REQ_INV, 32767, 0, 0, 16'h0000);
    send_vector(REQ_INV, 32767, 32767, 0, 16'h2000);
    send_vector(REQ_INV, -32768, -32768, 0, 16'hA000);
    send_vector(REQ_INV, 32767, 0, 32767, 16'h0000);
    send_vector(REQ_INV, -32768, 0, -32768, 16'h0000);
    send_vector(REQ_INV, 20000, -20000, 10000, 16'h5555);
    send_vector(REQ_INV, 0, 32767, -32768, 16'hFFFF);
    send_vector(REQ_INV, -32768, 32767, 32767, 16'hC000);
    send_vector(REQ_INV, 5000, 7000, -300, 16'h4000);
    send_vector(REQ_INV, -1, 1, -1, 16'hBFC0);
    drain_outputs();

    // Random: a back-to-back stretch, then gaps and stalls with a full drain midway
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    for (int n = 0; n < 550; n++) begin
      if (n == 150) begin
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
      end
      if (n == 400) drain_outputs();
      send_random();
    end

    drain_outputs();
    repeat (20) @(posedge clk);
    if (sb.awaited_outputs.size() != 0)
      $display("%0t: %0d output transactions never arrived", $time, sb.awaited_outputs.size());
    if (sb.errors == 0 && sb.awaited_outputs.size() == 0) begin
      $display("clarke_park_frame_transform verification clean");
    end else begin
      $display("clarke_park_frame_transform verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("clarke_park_frame_transform verification failed");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cpft_pkg.sv
hw/rtl/cpft_sincos.sv
hw/rtl/cpft_front.sv
hw/rtl/cpft_back.sv
hw/rtl/clarke_park_frame_transform.sv
tb/clarke_park_frame_transform_test.sv
